[sv/mhes_pkg.sv]
package mhes_pkg;

    localparam int DEPTH         = 1024;
    localparam int DATA_W        = 32;
    localparam int ADDR_W        = $clog2(DEPTH);
    localparam int CNT_W         = $clog2(DEPTH + 1);
    // child index {pos, 1} plus one spare bit for the right child
    localparam int CMP_W         = ADDR_W + 2;
    localparam int STATUS_W      = 2;
    localparam int COUNT_FIELD_W = 11;

    localparam logic OP_APPEND  = 1'b0;
    localparam logic OP_EXTRACT = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FETCH,
        S_LOAD,
        S_READ,
        S_CMP
    } t_state;

    typedef struct packed {
        logic signed [DATA_W-1:0] max_value;
        logic [STATUS_W-1:0]      status;
        logic [COUNT_FIELD_W-1:0] count;
    } t_result;

endpackage

[sv/mhes_ram.sv]
module mhes_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr_a,
    output logic [WIDTH-1:0]         o_rd_data_a,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr_b,
    output logic [WIDTH-1:0]         o_rd_data_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        o_rd_data_a <= r_mem[i_rd_addr_a];
        o_rd_data_b <= r_mem[i_rd_addr_b];
    end

endmodule

[sv/mhes_out_buf.sv]
module mhes_out_buf (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_res_valid,
    input  mhes_pkg::t_result  i_res,
    output logic               o_res_ready,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output mhes_pkg::t_result  o_out
);

    logic              r_hold_valid, n_hold_valid;
    mhes_pkg::t_result r_hold, n_hold;
    logic              r_out_valid, n_out_valid;
    mhes_pkg::t_result r_out, n_out;
    logic              move;

    // advance the held result whenever the output register is free or draining
    assign move = r_hold_valid && (!r_out_valid || !i_out_stall);

    always_comb begin
        n_hold_valid = r_hold_valid;
        n_hold       = r_hold;
        n_out_valid  = r_out_valid;
        n_out        = r_out;
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
        if (move) begin
            n_out_valid  = 1'b1;
            n_out        = r_hold;
            n_hold_valid = 1'b0;
        end
        if (i_res_valid) begin
            n_hold_valid = 1'b1;
            n_hold       = i_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_hold_valid <= n_hold_valid;
            r_out_valid  <= n_out_valid;
        end
        r_hold <= n_hold;
        r_out  <= n_out;
    end

    assign o_res_ready = !r_hold_valid;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

[sv/mhes_ctrl.sv]
module mhes_ctrl (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic                               i_opcode,
    input  logic signed [mhes_pkg::DATA_W-1:0] i_value,
    output logic                               o_res_valid,
    output mhes_pkg::t_result                  o_res,
    input  logic                               i_res_ready,
    output logic                               o_wr_en,
    output logic [mhes_pkg::ADDR_W-1:0]        o_wr_addr,
    output logic [mhes_pkg::DATA_W-1:0]        o_wr_data,
    output logic [mhes_pkg::ADDR_W-1:0]        o_rd_addr_a,
    input  logic [mhes_pkg::DATA_W-1:0]        i_rd_data_a,
    output logic [mhes_pkg::ADDR_W-1:0]        o_rd_addr_b,
    input  logic [mhes_pkg::DATA_W-1:0]        i_rd_data_b
);

    mhes_pkg::t_state                   r_state, n_state;
    logic [mhes_pkg::CNT_W-1:0]         r_count, n_count;
    logic [mhes_pkg::ADDR_W-1:0]        r_pos, n_pos;
    logic signed [mhes_pkg::DATA_W-1:0] r_elem, n_elem;
    logic signed [mhes_pkg::DATA_W-1:0] r_max, n_max;

    logic                               accept;
    logic                               full;
    logic [mhes_pkg::CMP_W-1:0]         left_idx, right_idx, cnt_ext;
    logic                               left_in, right_in;
    logic signed [mhes_pkg::DATA_W-1:0] left_val, right_val, cur_val;
    logic                               left_gt, right_gt;

    assign accept   = i_in_valid && !o_in_stall;
    assign full     = (r_count == mhes_pkg::CNT_W'(mhes_pkg::DEPTH));

    // children of the hole; they lie below the count or are ignored
    assign left_idx  = mhes_pkg::CMP_W'({r_pos, 1'b1});
    assign right_idx = left_idx + mhes_pkg::CMP_W'(1);
    assign cnt_ext   = mhes_pkg::CMP_W'(r_count);
    assign left_in   = left_idx < cnt_ext;
    assign right_in  = right_idx < cnt_ext;

    assign left_val  = i_rd_data_a;
    assign right_val = i_rd_data_b;
    assign left_gt   = left_val > r_elem;
    assign cur_val   = left_gt ? left_val : r_elem;
    assign right_gt  = right_in && (right_val > cur_val);

    assign o_in_stall = (r_state != mhes_pkg::S_IDLE) || !i_res_ready;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            mhes_pkg::S_IDLE: begin
                if (accept && i_opcode == mhes_pkg::OP_EXTRACT && r_count != '0) begin
                    n_state = mhes_pkg::S_FETCH;
                end
            end
            mhes_pkg::S_FETCH: n_state = mhes_pkg::S_LOAD;
            mhes_pkg::S_LOAD: begin
                n_state = (r_count == '0) ? mhes_pkg::S_IDLE : mhes_pkg::S_READ;
            end
            mhes_pkg::S_READ: begin
                n_state = left_in ? mhes_pkg::S_CMP : mhes_pkg::S_IDLE;
            end
            mhes_pkg::S_CMP: begin
                n_state = (left_gt || right_gt) ? mhes_pkg::S_READ : mhes_pkg::S_IDLE;
            end
            default: n_state = mhes_pkg::S_IDLE;
        endcase
    end

    // memory control, result and datapath updates
    always_comb begin
        n_count     = r_count;
        n_pos       = r_pos;
        n_elem      = r_elem;
        n_max       = r_max;
        o_wr_en     = 1'b0;
        o_wr_addr   = r_pos;
        o_wr_data   = r_elem;
        o_rd_addr_a = left_idx[mhes_pkg::ADDR_W-1:0];
        o_rd_addr_b = right_idx[mhes_pkg::ADDR_W-1:0];
        o_res_valid = 1'b0;
        o_res.max_value = '0;
        o_res.status    = mhes_pkg::ST_OK;
        o_res.count     = mhes_pkg::COUNT_FIELD_W'(r_count);
        case (r_state)
            mhes_pkg::S_IDLE: begin
                if (accept) begin
                    if (i_opcode == mhes_pkg::OP_APPEND) begin
                        o_res_valid = 1'b1;
                        if (full) begin
                            o_res.status = mhes_pkg::ST_FULL;
                        end else begin
                            o_wr_en     = 1'b1;
                            o_wr_addr   = r_count[mhes_pkg::ADDR_W-1:0];
                            o_wr_data   = i_value;
                            n_count     = r_count + mhes_pkg::CNT_W'(1);
                            o_res.count = mhes_pkg::COUNT_FIELD_W'(n_count);
                        end
                    end else if (r_count == '0) begin
                        o_res_valid  = 1'b1;
                        o_res.status = mhes_pkg::ST_EMPTY;
                    end else begin
                        n_count = r_count - mhes_pkg::CNT_W'(1);
                    end
                end
            end
            mhes_pkg::S_FETCH: begin
                // root on port a, last element on port b
                o_rd_addr_a = '0;
                o_rd_addr_b = r_count[mhes_pkg::ADDR_W-1:0];
            end
            mhes_pkg::S_LOAD: begin
                n_max  = i_rd_data_a;
                n_elem = i_rd_data_b;
                n_pos  = '0;
                if (r_count == '0) begin
                    o_res_valid     = 1'b1;
                    o_res.max_value = i_rd_data_a;
                end
            end
            mhes_pkg::S_READ: begin
                if (!left_in) begin
                    o_wr_en         = 1'b1;
                    o_res_valid     = 1'b1;
                    o_res.max_value = r_max;
                end
            end
            mhes_pkg::S_CMP: begin
                o_wr_en = 1'b1;
                if (right_gt) begin
                    o_wr_data = right_val;
                    n_pos     = right_idx[mhes_pkg::ADDR_W-1:0];
                end else if (left_gt) begin
                    o_wr_data = left_val;
                    n_pos     = left_idx[mhes_pkg::ADDR_W-1:0];
                end else begin
                    o_res_valid     = 1'b1;
                    o_res.max_value = r_max;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mhes_pkg::S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
        r_pos  <= n_pos;
        r_elem <= n_elem;
        r_max  <= n_max;
    end

    a_wr_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_wr_en |-> (r_state == mhes_pkg::S_IDLE || r_state == mhes_pkg::S_READ
                     || r_state == mhes_pkg::S_CMP))
        else $error("memory write outside idle or sift states");

    a_res_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> i_res_ready)
        else $error("result produced while result buffer full");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= mhes_pkg::CNT_W'(mhes_pkg::DEPTH))
        else $error("element count beyond depth");

    a_hole_inside: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == mhes_pkg::S_CMP) |-> (mhes_pkg::CMP_W'(r_pos) < cnt_ext))
        else $error("sift hole outside the heap");

    a_append_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_opcode == mhes_pkg::OP_APPEND && !full)
        |=> (r_count == $past(r_count) + mhes_pkg::CNT_W'(1)))
        else $error("append did not grow the count");

endmodule

[sv/max_heap_extract_sift_down_top.sv]
// Binary max-heap with append and extract-maximum.
// Input channel: i_in_valid / o_in_stall carry one item (i_opcode, i_value).
//   Append writes the value at the end of the heap without sifting, so the
//   loader supplies elements already in heap order. Extract returns the root,
//   moves the last element to the root and sifts it down.
// Output channel: o_out_valid / i_out_stall carry exactly one result per item
//   (o_max_value, o_status, o_count).
// Append or any error yields its result in the idle state; extract steps through
//   S_FETCH and S_LOAD, then an S_READ and S_CMP pair per heap level walked.
//   Results reach o_out_valid through the holding and output registers.
//   Each level reads both children from the dual-read heap memory in S_READ,
//   then compares and writes the hole in S_CMP; this loop sets the throughput.
// One item is in work at a time; the next is taken once the previous one has
//   finished and the result slot is free.
// A finished result waits in a holding register while the output register is
//   stalled, so one more item is taken during an output stall; after that the
//   input stalls until the receiver drains.
// Reset empties the heap (count zero) and clears both result slots; memory
//   contents are not cleared and need no clearing pass.
module max_heap_extract_sift_down_top (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic                               i_opcode,
    input  logic signed [mhes_pkg::DATA_W-1:0] i_value,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic signed [mhes_pkg::DATA_W-1:0] o_max_value,
    output logic [mhes_pkg::STATUS_W-1:0]      o_status,
    output logic [mhes_pkg::COUNT_FIELD_W-1:0] o_count
);

    logic                        res_valid, res_ready;
    mhes_pkg::t_result           res, out;
    logic                        wr_en;
    logic [mhes_pkg::ADDR_W-1:0] wr_addr, rd_addr_a, rd_addr_b;
    logic [mhes_pkg::DATA_W-1:0] wr_data, rd_data_a, rd_data_b;

    // heap storage: one write port, two registered read ports for the children
    mhes_ram #(
        .WIDTH (mhes_pkg::DATA_W),
        .DEPTH (mhes_pkg::DEPTH)
    ) u_ram (
        .i_clk       (i_clk),
        .i_wr_en     (wr_en),
        .i_wr_addr   (wr_addr),
        .i_wr_data   (wr_data),
        .i_rd_addr_a (rd_addr_a),
        .o_rd_data_a (rd_data_a),
        .i_rd_addr_b (rd_addr_b),
        .o_rd_data_b (rd_data_b)
    );

    // sequencer: append, root fetch and the sift-down walk
    mhes_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_opcode    (i_opcode),
        .i_value     (i_value),
        .o_res_valid (res_valid),
        .o_res       (res),
        .i_res_ready (res_ready),
        .o_wr_en     (wr_en),
        .o_wr_addr   (wr_addr),
        .o_wr_data   (wr_data),
        .o_rd_addr_a (rd_addr_a),
        .i_rd_data_a (rd_data_a),
        .o_rd_addr_b (rd_addr_b),
        .i_rd_data_b (rd_data_b)
    );

    // hold a finished result while the receiver stalls
    mhes_out_buf u_out_buf (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_res_valid (res_valid),
        .i_res       (res),
        .o_res_ready (res_ready),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (out)
    );

    assign o_max_value = out.max_value;
    assign o_status    = out.status;
    assign o_count     = out.count;

endmodule

[tb/tb.sv]
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic signed [mhes_pkg::DATA_W-1:0] HEAP_MAX =
        {1'b0, {(mhes_pkg::DATA_W-1){1'b1}}};
    localparam logic signed [mhes_pkg::DATA_W-1:0] HEAP_MIN =
        {1'b1, {(mhes_pkg::DATA_W-1){1'b0}}};
    localparam int RESET_CYCLES = 3;
    // longest extract latency plus both result slots, with margin
    localparam int DRAIN_CYCLES = 60;
    localparam int HOLD_CYCLES  = 300;
    // fill level of the ordered phase; deep enough to walk nine levels
    localparam int FILL_LEVEL   = 300;
    localparam int MIX_ITEMS    = 300;

    typedef struct {
        logic                               op;
        logic signed [mhes_pkg::DATA_W-1:0] value;
    } t_heap_cmd;

    // DUT pins; every input starts at a known value
    logic                                i_clk       = 1'b0;
    logic                                i_rst_n     = 1'b0;
    logic                                i_in_valid  = 1'b0;
    logic                                i_opcode    = mhes_pkg::OP_APPEND;
    logic signed [mhes_pkg::DATA_W-1:0]  i_value     = '0;
    logic                                i_out_stall = 1'b0;
    logic                                o_in_stall;
    logic                                o_out_valid;
    logic signed [mhes_pkg::DATA_W-1:0]  o_max_value;
    logic [mhes_pkg::STATUS_W-1:0]       o_status;
    logic [mhes_pkg::COUNT_FIELD_W-1:0]  o_count;

    // Items waiting to be offered and results waiting to come back
    t_heap_cmd         pending_cmds[$];
    mhes_pkg::t_result expected_results[$];

    // Shadow heap, updated at the moment an item is accepted
    logic signed [mhes_pkg::DATA_W-1:0] heap_mem [mhes_pkg::DEPTH];
    int                                 heap_cnt = 0;

    // Stimulus planning: expected fill level and a falling floor that keeps
    // appends in heap order (each new value is no larger than any held value)
    int     plan_cnt  = 0;
    longint floor_val = HEAP_MAX;

    int   cmds_accepted = 0;
    int   results_seen  = 0;
    int   cmd_wait      = 0;
    int   res_wait      = 0;
    int   err_cnt       = 0;
    logic hold_off      = 1'b0;

    max_heap_extract_sift_down_top uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_opcode    (i_opcode),
        .i_value     (i_value),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_max_value (o_max_value),
        .o_status    (o_status),
        .o_count     (o_count)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Apply one operation to the shadow heap and return the result it causes.
    // Extract pulls the root, moves the last element up and walks it down,
    // always toward the larger child; on a tie the left child wins.
    function automatic mhes_pkg::t_result predict_heap_op(
        input logic                               op,
        input logic signed [mhes_pkg::DATA_W-1:0] v);
        mhes_pkg::t_result                  r;
        int                                 pos;
        int                                 lt;
        int                                 rt;
        int                                 big;
        logic                               done;
        logic signed [mhes_pkg::DATA_W-1:0] tmp;
        r.max_value = '0;
        r.status    = mhes_pkg::ST_OK;
        if (op == mhes_pkg::OP_APPEND) begin
            if (heap_cnt >= mhes_pkg::DEPTH) begin
                r.status = mhes_pkg::ST_FULL;
            end else begin
                heap_mem[heap_cnt] = v;
                heap_cnt++;
            end
        end else if (heap_cnt == 0) begin
            r.status = mhes_pkg::ST_EMPTY;
        end else begin
            r.max_value = heap_mem[0];
            heap_cnt--;
            heap_mem[0] = heap_mem[heap_cnt];
            pos  = 0;
            done = (heap_cnt == 0);
            while (!done) begin
                lt  = 2 * pos + 1;
                rt  = lt + 1;
                big = pos;
                if (lt < heap_cnt && heap_mem[lt] > heap_mem[big]) big = lt;
                if (rt < heap_cnt && heap_mem[rt] > heap_mem[big]) big = rt;
                if (big == pos) begin
                    done = 1'b1;
                end else begin
                    tmp           = heap_mem[pos];
                    heap_mem[pos] = heap_mem[big];
                    heap_mem[big] = tmp;
                    pos           = big;
                end
            end
        end
        r.count = heap_cnt[mhes_pkg::COUNT_FIELD_W-1:0];
        return r;
    endfunction

    task automatic queue_append(input logic signed [mhes_pkg::DATA_W-1:0] v);
        t_heap_cmd c;
        c.op    = mhes_pkg::OP_APPEND;
        c.value = v;
        pending_cmds.push_back(c);
        if (plan_cnt < mhes_pkg::DEPTH) plan_cnt++;
    endtask

    // Append a value just below the floor; a zero step repeats the last value
    // so that equal siblings show up
    task automatic queue_ordered_append(input int unsigned max_step);
        longint v;
        v = floor_val;
        if ($urandom_range(0, 3) != 0) v = v - longint'($urandom_range(0, max_step));
        if (v < longint'(HEAP_MIN)) v = HEAP_MIN;
        floor_val = v;
        queue_append(v[mhes_pkg::DATA_W-1:0]);
    endtask

    task automatic queue_extract();
        t_heap_cmd c;
        c.op    = mhes_pkg::OP_EXTRACT;
        c.value = $urandom();
        pending_cmds.push_back(c);
        if (plan_cnt > 0) plan_cnt--;
        // Restart the floor once the heap has drained: high or anywhere
        if (plan_cnt == 0) begin
            if ($urandom_range(0, 1) == 0) floor_val = HEAP_MAX;
            else floor_val = longint'($signed($urandom()));
        end
    endtask

    // Driver: offer the next item once its drawn gap has run out; hold the
    // payload steady while the block stalls
    always @(posedge i_clk) begin : cmd_driver
        t_heap_cmd c;
        logic      nxt_valid;
        logic      quiet;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            nxt_valid = i_in_valid;
            // Some stretches run back to back with no gaps at all
            quiet = ((cmds_accepted / 200) % 4 == 2);
            if (i_in_valid && !o_in_stall) begin
                expected_results.push_back(predict_heap_op(i_opcode, i_value));
                cmds_accepted <= cmds_accepted + 1;
                nxt_valid = 1'b0;
            end
            if (!nxt_valid) begin
                if (cmd_wait > 0) begin
                    cmd_wait <= cmd_wait - 1;
                end else if (pending_cmds.size() > 0) begin
                    c = pending_cmds.pop_front();
                    i_opcode  <= c.op;
                    i_value   <= c.value;
                    nxt_valid = 1'b1;
                    cmd_wait  <= quiet ? 0 : $urandom_range(0, 9);
                end
            end
            i_in_valid <= nxt_valid;
        end
    end

    // Monitor: take each result, compare it with the oldest expectation, then
    // draw how long to stall before the next one
    always @(posedge i_clk) begin : result_monitor
        mhes_pkg::t_result want;
        int                nxt_wait;
        logic              quiet;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            res_wait    <= 0;
        end else begin
            nxt_wait = res_wait;
            quiet    = ((results_seen / 150) % 3 == 1);
            if (o_out_valid && !i_out_stall) begin
                results_seen <= results_seen + 1;
                if (expected_results.size() == 0) begin
                    $error("unexpected result: max_value %0d status %0d count %0d",
                           o_max_value, o_status, o_count);
                    err_cnt++;
                end else begin
                    want = expected_results.pop_front();
                    if (o_max_value !== want.max_value) begin
                        $error("max_value: expected %0d, got %0d", want.max_value, o_max_value);
                        err_cnt++;
                    end
                    if (o_status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, o_status);
                        err_cnt++;
                    end
                    if (o_count !== want.count) begin
                        $error("count: expected %0d, got %0d", want.count, o_count);
                        err_cnt++;
                    end
                end
                nxt_wait = quiet ? 0 : $urandom_range(0, 9);
            end else if (nxt_wait > 0) begin
                nxt_wait--;
            end
            res_wait    <= nxt_wait;
            i_out_stall <= hold_off || (nxt_wait > 0);
        end
    end

    // Back-pressure: stop draining results for a long stretch, once while the
    // heap fills and once in the mixed traffic, so the block backs up and
    // stalls its input while the driver keeps offering
    initial begin : long_hold
        int thresholds[2];
        thresholds = '{150, 700};
        foreach (thresholds[k]) begin
            while (cmds_accepted < thresholds[k]) @(posedge i_clk);
            hold_off <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge i_clk);
            hold_off <= 1'b0;
        end
    end

    initial begin : stimulus
        int bias;
        int r;
        // Directed: empty extract, single element, then a small heap with the
        // extremes and equal siblings so the walk breaks ties to the left
        queue_extract();
        queue_append(HEAP_MAX);
        queue_extract();
        queue_append(HEAP_MAX);
        queue_append(5);
        queue_append(5);
        queue_append(3);
        queue_append(3);
        queue_append(HEAP_MIN);
        queue_append(-1);
        queue_append(0);
        repeat (9) queue_extract();

        // Fill a deep heap in heap order, break the order with a few raw
        // values, then drain past empty
        floor_val = HEAP_MAX;
        while (plan_cnt < FILL_LEVEL) queue_ordered_append(4_000_000);
        repeat (3) queue_append($urandom());
        queue_extract();
        queue_ordered_append(1000);
        queue_append($urandom());
        repeat (FILL_LEVEL + 6) queue_extract();

        // Mixed traffic: mostly heap-ordered appends and extracts, first
        // leaning toward growth then toward draining, plus raw random appends
        // that break heap order
        for (int i = 0; i < MIX_ITEMS; i++) begin
            bias = (i < MIX_ITEMS / 2) ? 62 : 40;
            r    = $urandom_range(0, 99);
            if (r < 8) queue_append($urandom());
            else if (r < bias) queue_ordered_append(32'd1 << $urandom_range(0, 26));
            else queue_extract();
        end

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Wait for every item to go in and every result to come back
        while (pending_cmds.size() > 0 || i_in_valid || expected_results.size() > 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (err_cnt == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    // Watchdog: the slowest legal run stays well under this
    initial begin : watchdog
        #5ms;
        $display("TB_ERROR");
        $finish;
    end

endmodule

[filelist.f]
sv/mhes_pkg.sv
sv/mhes_ram.sv
sv/mhes_out_buf.sv
sv/mhes_ctrl.sv
sv/max_heap_extract_sift_down_top.sv
tb/tb.sv
